// ===== rtl/core/sbftp_pkg.sv =====
// Shared types and constants for the SBUS frame to PPM channel decoder.
`default_nettype none

package sbftp_pkg;

    // Frame and channel geometry
    localparam int FRAME_BITS = 176;
    localparam int CH_BITS    = 11;
    localparam int NUM_LANES  = 9;
    localparam int NUM_PPM    = 8;

    typedef logic [11:0] t_pulse;

    // Source channel of each lane; the last lane carries the rover select channel
    typedef logic [3:0] t_src_tab [0:NUM_LANES-1];
    localparam t_src_tab SRC_OF = '{4'd2, 4'd0, 4'd4, 4'd5, 4'd10, 4'd11, 4'd6, 4'd7, 4'd8};
    localparam int SEL_LANE = 8;

    // Outputs that are mirrored around the center as 3000 - v
    localparam logic [NUM_PPM-1:0] INVERT_MASK = 8'b1100_1110;

    // Scaling: (x - 172) * 1000 / 1639 + 1000
    localparam logic [10:0] SCALE_IN_MIN  = 11'd172;
    localparam t_pulse      SCALE_OUT_MIN = 12'd1000;
    // ceil(2^32 / 1639) * 1000; exact for every magnitude up to 1875 * 1000
    localparam logic [31:0] RECIP_MUL     = 32'd2620481000;
    localparam int          RECIP_SHIFT   = 32;

    // Clamp limits and inversion base
    localparam t_pulse      PULSE_MIN   = 12'd800;
    localparam t_pulse      PULSE_MAX   = 12'd2200;
    localparam t_pulse      SEL_MIN     = 12'd1000;
    localparam t_pulse      SEL_MAX     = 12'd2000;
    localparam t_pulse      INVERT_BASE = 12'd3000;

    // Reset values of the control registers
    localparam t_pulse      EMERG_THR_RST = 12'd1700;
    localparam t_pulse      AUTO_THR_RST  = 12'd1700;
    localparam t_pulse      NEUTRAL_RST   = 12'd1500;

    // Configuration register indexes
    localparam logic [1:0]  CFG_EMERG_THR = 2'd0;
    localparam logic [1:0]  CFG_AUTO_THR  = 2'd1;
    localparam logic [1:0]  CFG_NEUTRAL   = 2'd2;

    // Mode codes
    localparam logic [2:0]  MODE_HAND       = 3'd0;
    localparam logic [2:0]  MODE_ESTOP      = 3'd1;
    localparam logic [2:0]  MODE_AUTO_NO_HB = 3'd2;
    localparam logic [2:0]  MODE_AUTO_RUN   = 3'd3;
    localparam logic [2:0]  MODE_AUTO_STALE = 3'd4;

    typedef struct packed {
        logic [63:0] payload_low;
        logic [63:0] payload_mid;
        logic [47:0] payload_high;
        logic        heartbeat_alive;
        logic        command_fresh;
        logic [11:0] auto_throttle;
        logic [11:0] auto_steering;
    } t_in_word;

    typedef struct packed {
        logic [11:0] out_ch1;
        logic [11:0] out_ch2;
        logic [11:0] out_ch3;
        logic [11:0] out_ch4;
        logic [11:0] out_ch5;
        logic [11:0] out_ch6;
        logic [11:0] out_ch7;
        logic [11:0] out_ch8;
        logic [10:0] rover_select;
        logic [11:0] ungated_throttle;
        logic [11:0] ungated_steering;
        logic [2:0]  mode_code;
    } t_out_word;

    // Control registers as seen by the merge stage
    typedef struct packed {
        t_pulse emerg_thr;
        t_pulse auto_thr;
        t_pulse neutral;
    } t_cfg;

    // Side-band fields carried alongside the lanes
    typedef struct packed {
        logic        heartbeat_alive;
        logic        command_fresh;
        logic [11:0] auto_throttle;
        logic [11:0] auto_steering;
    } t_side;

endpackage

`default_nettype wire

// ===== rtl/core/sbus_frame_to_ppm_channels.sv =====
// Top level: SBUS frame to PPM channel decoder with mode gating.
// Each accepted input word passes the lane and then the merge register to its result word.
// Throughput: one word per cycle unless stalled; one 11x32 reciprocal multiply per lane.
// A full pipeline with a stalled output stalls the input; an empty slot is taken at once.
// Reset (synchronous, active low) empties the pipeline and loads the control
// registers with thresholds 1700 and neutral 1500.
`default_nettype none

module sbus_frame_to_ppm_channels (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire sbftp_pkg::t_in_word  i_in_word,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output sbftp_pkg::t_out_word      o_out_word,
    input  wire logic                 i_cfg_we,
    input  wire logic [1:0]           i_cfg_idx,
    input  wire logic [11:0]          i_cfg_data
);

    logic [sbftp_pkg::FRAME_BITS-1:0]           w_frame;
    sbftp_pkg::t_pulse [sbftp_pkg::NUM_LANES-1:0] w_lane_val;
    sbftp_pkg::t_cfg                            r_cfg;
    sbftp_pkg::t_side                           r_side;
    logic                                       r_v1;
    logic                                       r_v2;
    logic                                       w_en1;
    logic                                       w_en2;

    // Advance each stage when it is empty or the next one moves
    assign w_en2      = !r_v2 || !i_out_stall;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (w_en1) begin
                r_v1 <= i_in_valid;
            end
            if (w_en2) begin
                r_v2 <= r_v1;
            end
        end
    end

    // Write the control registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.emerg_thr <= sbftp_pkg::EMERG_THR_RST;
            r_cfg.auto_thr  <= sbftp_pkg::AUTO_THR_RST;
            r_cfg.neutral   <= sbftp_pkg::NEUTRAL_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                sbftp_pkg::CFG_EMERG_THR: r_cfg.emerg_thr <= i_cfg_data;
                sbftp_pkg::CFG_AUTO_THR:  r_cfg.auto_thr  <= i_cfg_data;
                sbftp_pkg::CFG_NEUTRAL:   r_cfg.neutral   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Carry the side-band fields alongside the lane registers
    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_side.heartbeat_alive <= i_in_word.heartbeat_alive;
            r_side.command_fresh   <= i_in_word.command_fresh;
            r_side.auto_throttle   <= i_in_word.auto_throttle;
            r_side.auto_steering   <= i_in_word.auto_steering;
        end
    end

    // Pack the payload with byte 1 at the bottom
    assign w_frame = {i_in_word.payload_high, i_in_word.payload_mid, i_in_word.payload_low};

    // One lane per scaled channel
    for (genvar g = 0; g < sbftp_pkg::NUM_LANES; g++) begin : g_lane
        sbftp_lane u_lane (
            .i_clk   (i_clk),
            .i_en    (w_en1),
            .i_chan  (w_frame[int'(sbftp_pkg::SRC_OF[g]) * sbftp_pkg::CH_BITS +: sbftp_pkg::CH_BITS]),
            .o_value (w_lane_val[g])
        );
    end

    sbftp_merge u_merge (
        .i_clk      (i_clk),
        .i_en       (w_en2),
        .i_lane_val (w_lane_val),
        .i_cfg      (r_cfg),
        .i_side     (r_side),
        .o_word     (o_out_word)
    );

    assign o_out_valid = r_v2;

    // Input stalls only when both stages hold words and the output is blocked
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v1 && o_out_valid && i_out_stall))
        else $error("input stalled while the pipeline has room");

    // Rover select stays inside its clamp range
    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.rover_select >= 11'd1000 &&
                         o_out_word.rover_select <= 11'd2000))
        else $error("rover select outside clamp range");

    // Manual mode passes the ungated throttle and steering through
    a_manual_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.mode_code == sbftp_pkg::MODE_HAND) |->
        (o_out_word.out_ch1 == o_out_word.ungated_throttle &&
         o_out_word.out_ch2 == o_out_word.ungated_steering))
        else $error("manual mode altered throttle or steering");

endmodule

`default_nettype wire

// ===== rtl/core/sbftp_lane.sv =====
// One scaling lane: offset, constant divide by reciprocal multiply, rebias.
`default_nettype none

module sbftp_lane (
    input  wire logic                  i_clk,
    input  wire logic                  i_en,
    input  wire logic [10:0]           i_chan,
    output sbftp_pkg::t_pulse          o_value
);

    logic        n_neg;
    logic [10:0] n_mag;
    logic [42:0] n_prod;
    logic        r_neg;
    logic [10:0] r_q;

    // Take the magnitude of the offset and divide it by the reciprocal multiply
    always_comb begin
        n_neg  = i_chan < sbftp_pkg::SCALE_IN_MIN;
        n_mag  = n_neg ? (sbftp_pkg::SCALE_IN_MIN - i_chan) : (i_chan - sbftp_pkg::SCALE_IN_MIN);
        n_prod = 43'(n_mag) * 43'(sbftp_pkg::RECIP_MUL);
    end

    // Hold the quotient and sign for the merge stage
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= n_neg;
            r_q   <= n_prod[sbftp_pkg::RECIP_SHIFT +: 11];
        end
    end

    // Rebias; truncation toward zero falls out of dividing the magnitude
    assign o_value = r_neg ? (sbftp_pkg::SCALE_OUT_MIN - {1'b0, r_q})
                           : (sbftp_pkg::SCALE_OUT_MIN + {1'b0, r_q});

endmodule

`default_nettype wire

// ===== rtl/core/sbftp_merge.sv =====
// Merge stage: clamp and invert lane values, decide the mode, gate throttle and steering.
`default_nettype none

module sbftp_merge (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_en,
    input  wire sbftp_pkg::t_pulse [sbftp_pkg::NUM_LANES-1:0] i_lane_val,
    input  wire sbftp_pkg::t_cfg                              i_cfg,
    input  wire sbftp_pkg::t_side                             i_side,
    output sbftp_pkg::t_out_word                              o_word
);

    sbftp_pkg::t_pulse [sbftp_pkg::NUM_PPM-1:0] n_pc;
    sbftp_pkg::t_pulse                          n_clip;
    sbftp_pkg::t_pulse                          n_sel;
    sbftp_pkg::t_pulse                          n_thr;
    sbftp_pkg::t_pulse                          n_str;
    logic [2:0]                                 n_mode;
    sbftp_pkg::t_out_word                       n_word;
    sbftp_pkg::t_out_word                       r_word;

    // Clamp each lane and mirror the inverted outputs
    always_comb begin
        for (int i = 0; i < sbftp_pkg::NUM_PPM; i++) begin
            n_clip = i_lane_val[i];
            if (n_clip < sbftp_pkg::PULSE_MIN) begin
                n_clip = sbftp_pkg::PULSE_MIN;
            end else if (n_clip > sbftp_pkg::PULSE_MAX) begin
                n_clip = sbftp_pkg::PULSE_MAX;
            end
            n_pc[i] = sbftp_pkg::INVERT_MASK[i] ? (sbftp_pkg::INVERT_BASE - n_clip) : n_clip;
        end
        n_sel = i_lane_val[sbftp_pkg::SEL_LANE];
        if (n_sel < sbftp_pkg::SEL_MIN) begin
            n_sel = sbftp_pkg::SEL_MIN;
        end else if (n_sel > sbftp_pkg::SEL_MAX) begin
            n_sel = sbftp_pkg::SEL_MAX;
        end
    end

    // Decide the mode; emergency wins over the autonomous switch
    always_comb begin
        n_thr  = i_cfg.neutral;
        n_str  = i_cfg.neutral;
        priority if (n_pc[2] < i_cfg.emerg_thr) begin
            n_mode = sbftp_pkg::MODE_ESTOP;
        end else if (n_pc[3] > i_cfg.auto_thr) begin
            priority if (!i_side.heartbeat_alive) begin
                n_mode = sbftp_pkg::MODE_AUTO_NO_HB;
            end else if (i_side.command_fresh) begin
                n_mode = sbftp_pkg::MODE_AUTO_RUN;
                n_thr  = i_side.auto_throttle;
                n_str  = i_side.auto_steering;
            end else begin
                n_mode = sbftp_pkg::MODE_AUTO_STALE;
            end
        end else begin
            n_mode = sbftp_pkg::MODE_HAND;
            n_thr  = n_pc[0];
            n_str  = n_pc[1];
        end
    end

    // Assemble the result word
    always_comb begin
        n_word.out_ch1          = n_thr;
        n_word.out_ch2          = n_str;
        n_word.out_ch3          = n_pc[2];
        n_word.out_ch4          = n_pc[3];
        n_word.out_ch5          = n_pc[4];
        n_word.out_ch6          = n_pc[5];
        n_word.out_ch7          = n_pc[6];
        n_word.out_ch8          = n_pc[7];
        n_word.rover_select     = n_sel[10:0];
        n_word.ungated_throttle = n_pc[0];
        n_word.ungated_steering = n_pc[1];
        n_word.mode_code        = n_mode;
    end

    // Hold the result word until the pipeline advances
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_word <= n_word;
        end
    end

    assign o_word = r_word;

endmodule

`default_nettype wire

// ===== test/tb_sbus_frame_to_ppm_channels.sv =====
// Self-checking testbench for the SBUS frame to PPM channel decoder.

module tb_sbus_frame_to_ppm_channels;
    timeunit 1ns;
    timeprecision 1ps;

    // Scaling and mapping constants of the decoder
    localparam int SRC_MIN   = 172;
    localparam int SRC_SPAN  = 1639;
    localparam int OUT_BASE  = 1000;
    localparam int OUT_SPAN  = 1000;
    localparam int MIRROR    = 3000;
    localparam int CLAMP_LO  = 800;
    localparam int CLAMP_HI  = 2200;
    localparam int SELECT_LO = 1000;
    localparam int SELECT_HI = 2000;

    // Source channel per output lane, four bits each, lane 0 in the low nibble
    localparam logic [31:0] LANE_SRC       = {4'd7, 4'd6, 4'd11, 4'd10, 4'd5, 4'd4, 4'd0, 4'd2};
    localparam logic [7:0]  MIRRORED_LANES = 8'b1100_1110;
    localparam int          EMERG_CH       = 4;
    localparam int          MODE_CH        = 5;
    localparam int          SELECT_CH      = 8;
    localparam int          MAX_REPORTS    = 40;

    logic                 i_clk    = 1'b0;
    logic                 i_rst_n  = 1'b0;
    logic                 in_valid = 1'b0;
    sbftp_pkg::t_in_word  in_word  = '0;
    logic                 out_stall = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [1:0]           cfg_idx  = sbftp_pkg::CFG_EMERG_THR;
    logic [11:0]          cfg_data = '0;
    wire                  in_stall;
    wire                  out_valid;
    sbftp_pkg::t_out_word out_word;

    // Mirror of the control registers
    sbftp_pkg::t_pulse cfg_emerg_thr = sbftp_pkg::EMERG_THR_RST;
    sbftp_pkg::t_pulse cfg_auto_thr  = sbftp_pkg::AUTO_THR_RST;
    sbftp_pkg::t_pulse cfg_neutral   = sbftp_pkg::NEUTRAL_RST;

    sbftp_pkg::t_in_word  frames_to_send[$];
    sbftp_pkg::t_out_word predicted_outputs[$];
    sbftp_pkg::t_out_word want;
    int        n_errors  = 0;
    int        idle_pct  = 0;
    int        gap_left  = 0;
    int        stall_left = 0;
    bit        send_fire;

    sbus_frame_to_ppm_channels u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_word  (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    always #1 i_clk = ~i_clk;

    function automatic int scale_pulse(input logic [10:0] raw);
        int d;
        d = int'(raw) - SRC_MIN;
        return d * OUT_SPAN / SRC_SPAN + OUT_BASE;
    endfunction

    function automatic int clamp_pulse(input int v, input int lo, input int hi);
        if (v < lo) return lo;
        if (v > hi) return hi;
        return v;
    endfunction

    // Decode one frame into the expected output word under the current registers
    function automatic sbftp_pkg::t_out_word decode_frame(input sbftp_pkg::t_in_word w);
        logic [175:0]         frame;
        int                   pc [8];
        int                   sel;
        int                   ch;
        sbftp_pkg::t_out_word r;
        frame = {w.payload_high, w.payload_mid, w.payload_low};
        for (int i = 0; i < 8; i++) begin
            ch = int'(LANE_SRC[4*i +: 4]);
            pc[i] = clamp_pulse(scale_pulse(frame[11*ch +: 11]), CLAMP_LO, CLAMP_HI);
            if (MIRRORED_LANES[i]) pc[i] = MIRROR - pc[i];
        end
        sel = clamp_pulse(scale_pulse(frame[11*SELECT_CH +: 11]), SELECT_LO, SELECT_HI);
        r.ungated_throttle = 12'(pc[0]);
        r.ungated_steering = 12'(pc[1]);
        // Gate throttle and steering; emergency wins over the mode switch
        if (pc[2] < int'(cfg_emerg_thr)) begin
            pc[0] = int'(cfg_neutral);
            pc[1] = int'(cfg_neutral);
            r.mode_code = sbftp_pkg::MODE_ESTOP;
        end else if (pc[3] > int'(cfg_auto_thr)) begin
            if (!w.heartbeat_alive) begin
                pc[0] = int'(cfg_neutral);
                pc[1] = int'(cfg_neutral);
                r.mode_code = sbftp_pkg::MODE_AUTO_NO_HB;
            end else if (w.command_fresh) begin
                pc[0] = int'(w.auto_throttle);
                pc[1] = int'(w.auto_steering);
                r.mode_code = sbftp_pkg::MODE_AUTO_RUN;
            end else begin
                pc[0] = int'(cfg_neutral);
                pc[1] = int'(cfg_neutral);
                r.mode_code = sbftp_pkg::MODE_AUTO_STALE;
            end
        end else begin
            r.mode_code = sbftp_pkg::MODE_HAND;
        end
        r.out_ch1      = 12'(pc[0]);
        r.out_ch2      = 12'(pc[1]);
        r.out_ch3      = 12'(pc[2]);
        r.out_ch4      = 12'(pc[3]);
        r.out_ch5      = 12'(pc[4]);
        r.out_ch6      = 12'(pc[5]);
        r.out_ch7      = 12'(pc[6]);
        r.out_ch8      = 12'(pc[7]);
        r.rover_select = 11'(sel);
        return r;
    endfunction

    // Build a frame from a base vector, overriding the switch and select channels where not negative
    function automatic sbftp_pkg::t_in_word directed_frame(input logic [175:0] base,
                                                input int c4,
                                                input int c5, input int c8, input bit hb,
                                                input bit fr, input int thr, input int str);
        sbftp_pkg::t_in_word w;
        if (c4 >= 0) base[11*EMERG_CH +: 11] = 11'(c4);
        if (c5 >= 0) base[11*MODE_CH +: 11] = 11'(c5);
        if (c8 >= 0) base[11*SELECT_CH +: 11] = 11'(c8);
        w.payload_low     = base[63:0];
        w.payload_mid     = base[127:64];
        w.payload_high    = base[175:128];
        w.heartbeat_alive = hb;
        w.command_fresh   = fr;
        w.auto_throttle   = 12'(thr);
        w.auto_steering   = 12'(str);
        return w;
    endfunction

    // Random frame, biased toward the autonomous branch and the switch thresholds
    function automatic sbftp_pkg::t_in_word random_frame();
        logic [191:0]        bits;
        sbftp_pkg::t_in_word w;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        case ($urandom_range(0, 3))
            1: begin
                bits[11*EMERG_CH +: 11] = 11'($urandom_range(0, 600));
                bits[11*MODE_CH +: 11]  = 11'($urandom_range(0, 600));
            end
            2: begin
                bits[11*EMERG_CH +: 11] = 11'($urandom_range(0, 640));
            end
            3: begin
                bits[11*EMERG_CH +: 11] = 11'($urandom_range(650, 680));
                bits[11*MODE_CH +: 11]  = 11'($urandom_range(650, 680));
            end
            default: ;
        endcase
        w.payload_low     = bits[63:0];
        w.payload_mid     = bits[127:64];
        w.payload_high    = bits[175:128];
        w.heartbeat_alive = ($urandom_range(0, 4) != 0);
        w.command_fresh   = ($urandom_range(0, 4) != 0);
        if ($urandom_range(0, 3) == 0) begin
            w.auto_throttle = 12'($urandom);
            w.auto_steering = 12'($urandom);
        end else begin
            w.auto_throttle = 12'($urandom_range(800, 2200));
            w.auto_steering = 12'($urandom_range(800, 2200));
        end
        return w;
    endfunction

    task automatic check_field(input string name, input logic [11:0] exp_v,
                               input logic [11:0] act_v);
        if (act_v !== exp_v) begin
            n_errors++;
            if (n_errors <= MAX_REPORTS)
                $display("%0t ns: %s expected %0d, actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    task automatic write_reg(input logic [1:0] idx, input sbftp_pkg::t_pulse value);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            sbftp_pkg::CFG_EMERG_THR: cfg_emerg_thr = value;
            sbftp_pkg::CFG_AUTO_THR:  cfg_auto_thr  = value;
            sbftp_pkg::CFG_NEUTRAL:   cfg_neutral   = value;
            default: ;
        endcase
    endtask

    // Hold until every frame is sent and every output word has come back
    task automatic wait_for_drain();
        while (frames_to_send.size() > 0 || in_valid || predicted_outputs.size() > 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Driver: predict on acceptance, then present the next word or idle
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            gap_left = 0;
        end else begin
            send_fire = in_valid && !in_stall;
            if (send_fire) predicted_outputs.push_back(decode_frame(in_word));
            if (!in_valid || send_fire) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if ($urandom_range(0, 99) < idle_pct) begin
                    gap_left = $urandom_range(0, 5);
                    in_valid <= 1'b0;
                end else if (frames_to_send.size() > 0) begin
                    in_word  <= frames_to_send.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted output word, then choose the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid === 1'b1 && !out_stall) begin
            if (predicted_outputs.size() == 0) begin
                n_errors++;
                if (n_errors <= MAX_REPORTS)
                    $display("%0t ns: output word expected none, actual mode %0d out_ch1 %0d",
                             $time, out_word.mode_code, out_word.out_ch1);
            end else begin
                want = predicted_outputs.pop_front();
                check_field("out_ch1", want.out_ch1, out_word.out_ch1);
                check_field("out_ch2", want.out_ch2, out_word.out_ch2);
                check_field("out_ch3", want.out_ch3, out_word.out_ch3);
                check_field("out_ch4", want.out_ch4, out_word.out_ch4);
                check_field("out_ch5", want.out_ch5, out_word.out_ch5);
                check_field("out_ch6", want.out_ch6, out_word.out_ch6);
                check_field("out_ch7", want.out_ch7, out_word.out_ch7);
                check_field("out_ch8", want.out_ch8, out_word.out_ch8);
                check_field("rover_select", 12'(want.rover_select),
                            12'(out_word.rover_select));
                check_field("ungated_throttle", want.ungated_throttle,
                            out_word.ungated_throttle);
                check_field("ungated_steering", want.ungated_steering,
                            out_word.ungated_steering);
                check_field("mode_code", 12'(want.mode_code), 12'(out_word.mode_code));
            end
        end
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if ($urandom_range(0, 99) < idle_pct) begin
            stall_left = $urandom_range(0, 5);
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Stimulus: directed frames under reset values, then register phases with random frames
    initial begin
        logic [175:0] zeros;
        logic [175:0] ones;
        logic [175:0] stripes;
        logic [191:0] noise;
        int           e_thr;
        int           a_thr;
        int           neutral;
        int           count;
        zeros   = '0;
        ones    = '1;
        stripes = {22{8'hA5}};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        idle_pct = 20;

        // Payload extremes
        frames_to_send.push_back(directed_frame(zeros, -1, -1, -1, 1'b0, 1'b0, 800, 2200));
        frames_to_send.push_back(directed_frame(ones, -1, -1, -1, 1'b1, 1'b1, 4095, 4095));
        frames_to_send.push_back(directed_frame(stripes, -1, -1, -1, 1'b1, 1'b0, 0, 0));
        frames_to_send.push_back(directed_frame(~stripes, -1, -1, -1, 1'b0, 1'b1, 2200, 800));
        // Manual mode, emergency, and emergency with the auto switch on
        frames_to_send.push_back(directed_frame(ones, 0, 2047, -1, 1'b1, 1'b1, 900, 900));
        frames_to_send.push_back(directed_frame(zeros, 2047, 2047, -1, 1'b1, 1'b1, 900, 900));
        frames_to_send.push_back(directed_frame(zeros, 2047, 0, -1, 1'b1, 1'b1, 900, 900));
        // Autonomous without heartbeat, with stale command, with fresh command
        frames_to_send.push_back(directed_frame(stripes, 0, 0, -1, 1'b0, 1'b1, 1200, 1300));
        frames_to_send.push_back(directed_frame(stripes, 0, 0, -1, 1'b1, 1'b0, 1200, 1300));
        frames_to_send.push_back(directed_frame(stripes, 0, 0, -1, 1'b1, 1'b1, 0, 4095));
        frames_to_send.push_back(directed_frame(stripes, 0, 0, -1, 1'b1, 1'b1, 4095, 0));
        frames_to_send.push_back(directed_frame(zeros, 0, 0, -1, 1'b1, 1'b1, 800, 2200));
        // Switch channels right at the thresholds
        frames_to_send.push_back(directed_frame(zeros, 665, 2047, -1, 1'b1, 1'b1, 1000, 1000));
        frames_to_send.push_back(directed_frame(zeros, 666, 2047, -1, 1'b1, 1'b1, 1000, 1000));
        frames_to_send.push_back(directed_frame(zeros, 0, 665, -1, 1'b1, 1'b1, 1000, 1000));
        frames_to_send.push_back(directed_frame(zeros, 0, 663, -1, 1'b1, 1'b1, 1000, 1000));
        // Rover select around both clamp limits
        frames_to_send.push_back(directed_frame(stripes, 0, 2047, 0, 1'b0, 1'b0, 800, 800));
        frames_to_send.push_back(directed_frame(stripes, 0, 2047, 171, 1'b0, 1'b0, 800, 800));
        frames_to_send.push_back(directed_frame(stripes, 0, 2047, 172, 1'b0, 1'b0, 800, 800));
        frames_to_send.push_back(directed_frame(stripes, 0, 2047, 1811, 1'b0, 1'b0, 800, 800));
        frames_to_send.push_back(directed_frame(stripes, 0, 2047, 1812, 1'b0, 1'b0, 800, 800));
        frames_to_send.push_back(directed_frame(stripes, 0, 2047, 2047, 1'b0, 1'b0, 800, 800));
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        frames_to_send.push_back(directed_frame(noise[175:0], -1, -1, -1, 1'b1, 1'b1, 2000, 1000));
        wait_for_drain();

        // Register phases; the last one runs with no idling at all
        for (int p = 0; p < 8; p++) begin
            e_thr   = $urandom_range(800, 2200);
            a_thr   = $urandom_range(800, 2200);
            neutral = $urandom_range(800, 2200);
            count   = 300;
            case (p)
                0: begin e_thr = 800;  a_thr = 800;  neutral = 800;  count = 60; end
                1: begin e_thr = 2200; a_thr = 2200; neutral = 2200; count = 60; end
                2: begin e_thr = 0;    a_thr = 4095; neutral = 0;    count = 40; end
                3: begin e_thr = 4095; a_thr = 0;    neutral = 4095; count = 40; end
                5: begin
                    e_thr   = int'(sbftp_pkg::EMERG_THR_RST);
                    a_thr   = int'(sbftp_pkg::AUTO_THR_RST);
                    neutral = int'(sbftp_pkg::NEUTRAL_RST);
                end
                6: begin
                    e_thr = $urandom_range(1200, 1900);
                    a_thr = $urandom_range(1100, 1900);
                end
                default: ;
            endcase
            write_reg(sbftp_pkg::CFG_EMERG_THR, 12'(e_thr));
            write_reg(sbftp_pkg::CFG_AUTO_THR, 12'(a_thr));
            write_reg(sbftp_pkg::CFG_NEUTRAL, 12'(neutral));
            case (p % 3)
                0:       idle_pct = 25;
                1:       idle_pct = 0;
                default: idle_pct = 10;
            endcase
            if (p == 7) idle_pct = 0;
            repeat (count) frames_to_send.push_back(random_frame());
            wait_for_drain();
        end

        if (n_errors == 0 && predicted_outputs.size() == 0) begin
            $display("sbus_frame_to_ppm_channels test passed");
        end else begin
            $display("sbus_frame_to_ppm_channels test failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2_000_000;
        $display("sbus_frame_to_ppm_channels test failed");
        $finish;
    end

endmodule
